// ===== rtl/kmv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_pkg
// Shared constants and codes for the distinct-count sketch.
// ----------------------------------------------------------------------------
package kmv_pkg;

  // sketch geometry
  localparam int SKETCH_SIZE = 1024;
  localparam int KEY_BYTES   = 8;
  localparam int ADDR_W      = (SKETCH_SIZE > 1) ? $clog2(SKETCH_SIZE) : 1;
  localparam int CNT_W       = 11;

  // field widths
  localparam int REQ_W = 2;
  localparam int KEY_W = 64;
  localparam int EST_W = 42;
  localparam int HASH_W = 32;

  // hash multiplier
  localparam logic [31:0] MM_MUL = 32'h5bd1e995;

  // estimate constants
  localparam longint unsigned K_MUL = (SKETCH_SIZE > 1) ? SKETCH_SIZE - 1 : SKETCH_SIZE;
  localparam logic [EST_W-1:0] EST_NUM = EST_W'(K_MUL * 64'hFFFF_FFFF);
  localparam logic [EST_W-1:0] EST_MAX = '1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // register index
  localparam logic REG_HASH_SEED = 1'b0;

endpackage
`default_nettype wire

// ===== rtl/kmv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_if
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kmv_in_if import kmv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key_value;
  modport source (output valid, req_type, key_value, input ready);
  modport sink   (input valid, req_type, key_value, output ready);
endinterface

interface kmv_out_if import kmv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EST_W-1:0]  estimate;
  logic [CNT_W-1:0]  stored_count;
  logic [HASH_W-1:0] largest_hash;
  logic              saturated;
  modport source (output valid, estimate, stored_count, largest_hash, saturated,
                  input ready);
  modport sink   (input valid, estimate, stored_count, largest_hash, saturated,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/kmv_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_hash
// Iterative MurmurHash2 over one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module kmv_hash import kmv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [31:0]       seed,
  output logic                   done,
  output logic [HASH_W-1:0]      hash
);

  localparam int NBLK = KEY_BYTES / 4;
  localparam int TAIL_BITS = 8 * (KEY_BYTES % 4);
  localparam logic [63:0] TAIL_MASK = 64'((65'(1) << TAIL_BITS) - 65'(1));

  typedef enum logic [2:0] {H_IDLE, H_K1, H_K2, H_H, H_T, H_F, H_DONE} hstate_t;

  hstate_t     state_r;
  logic [63:0] key_r;
  logic [31:0] k_r, h_r;
  logic [1:0]  blk_r;
  logic [31:0] mul_a, prod, kblk, tail;

  assign kblk = 32'(key_r >> {blk_r, 5'b0});
  assign tail = 32'((key_r >> (NBLK * 32)) & TAIL_MASK);

  // select the multiplier operand for this step
  always_comb begin
    case (state_r)
      H_K1:    mul_a = kblk;
      H_K2:    mul_a = k_r ^ (k_r >> 24);
      H_H:     mul_a = h_r;
      H_T:     mul_a = h_r ^ tail;
      H_F:     mul_a = h_r ^ (h_r >> 13);
      default: mul_a = h_r;
    endcase
  end

  assign prod = 32'(mul_a * MM_MUL);
  assign done = (state_r == H_DONE);
  assign hash = h_r ^ (h_r >> 15);

  // sequence the mixing steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      unique case (state_r)
        H_IDLE: begin
          if (start) begin
            key_r <= key;
            h_r   <= seed ^ 32'(KEY_BYTES);
            blk_r <= '0;
            if (NBLK > 0)       state_r <= H_K1;
            else if (TAIL_BITS > 0) state_r <= H_T;
            else                state_r <= H_F;
          end
        end
        H_K1: begin
          k_r <= prod;
          state_r <= H_K2;
        end
        H_K2: begin
          k_r <= prod;
          state_r <= H_H;
        end
        H_H: begin
          h_r   <= prod ^ k_r;
          blk_r <= blk_r + 2'd1;
          if (32'(blk_r) + 1 < NBLK) state_r <= H_K1;
          else if (TAIL_BITS > 0)    state_r <= H_T;
          else                       state_r <= H_F;
        end
        H_T: begin
          h_r <= prod;
          state_r <= H_F;
        end
        H_F: begin
          h_r <= prod;
          state_r <= H_DONE;
        end
        H_DONE: state_r <= H_IDLE;
        default: state_r <= H_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kmv_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmv_div import kmv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [EST_W-1:0]  num,
  input  wire logic [HASH_W-1:0] den,
  output logic                   done,
  output logic [EST_W-1:0]       quo
);

  localparam int STEP_W = $clog2(EST_W + 1);

  logic [HASH_W:0]   rem_r;
  logic [EST_W-1:0]  quo_r;
  logic [HASH_W-1:0] den_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [HASH_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_r[HASH_W-1:0], quo_r[EST_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign done   = done_r;
  assign quo    = quo_r;

  // shift in one numerator bit and trial-subtract each cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
        cnt_r  <= STEP_W'(EST_W);
      end else if (busy_r) begin
        rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
        quo_r <= {quo_r[EST_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kmv_distinct_count_sketch_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_distinct_count_sketch_core
// K-minimum-values distinct-count sketch with a sorted hash store.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one request per transaction: insert a key, query the
//   estimate or clear the store. out_if returns exactly one result per
//   request with the estimate, count, largest held hash and saturation flag.
//   The APB port holds the hash seed at register 0 (write only while idle).
// Processing:
//   One request is processed at a time; in_if.ready is high only when idle.
//   An insert hashes the key on the hash unit's shared multiplier, then
//   scans down the store one entry at a time (read, then compare) until
//   the slot is found, then shifts entries one slot at a time (read, then
//   write). A query on a full store whose largest hash is nonzero adds a
//   divide. The store memory has one read port and one write port.
// Reset:
//   Reset empties the store (count 0) and clears the seed; no memory sweep.
// Backpressure:
//   A finished result sits in the output register; the next request is
//   accepted meanwhile and waits at completion until the register frees up.
// ----------------------------------------------------------------------------
module kmv_distinct_count_sketch_core import kmv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  kmv_in_if.sink           in_if,
  kmv_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_SCAN_RD, S_SCAN_CHK, S_PLAN, S_MV_RD, S_MV_WR,
    S_PUT, S_TOP_RD, S_TOP_CHK, S_DIV, S_OUT
  } state_t;

  state_t            state_r;
  logic [31:0]       seed_r;
  logic [REQ_W-1:0]  req_r;
  logic [HASH_W-1:0] h_r;
  logic [CNT_W-1:0]  cnt_r, idx_r, above_r, mv_r;
  logic [EST_W-1:0]  est_r;
  logic              sat_r;
  logic [HASH_W-1:0] largest_r;
  logic              out_valid_r;
  logic [EST_W-1:0]  out_est_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [HASH_W-1:0] out_largest_r;
  logic              out_sat_r;

  logic [HASH_W-1:0] mem [SKETCH_SIZE];
  logic [HASH_W-1:0] rd_q;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [HASH_W-1:0] mem_wdata;
  logic              mem_we;

  logic              in_acc, full, hash_start, hash_done, div_start, div_done;
  logic [HASH_W-1:0] hash_val;
  logic [EST_W-1:0]  quo;
  logic [CNT_W-1:0]  src_idx, dst_idx, put_idx;

  assign in_acc = in_if.valid & in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign full = (cnt_r == CNT_W'(SKETCH_SIZE));
  assign hash_start = in_acc && (in_if.req_type == REQ_INSERT);
  assign div_start = (state_r == S_TOP_CHK) && (req_r == REQ_QUERY) && full &&
                     (rd_q != '0);

  // APB register access
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HASH_SEED) ? seed_r : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_HASH_SEED) begin
      seed_r <= pwdata;
    end
  end

  kmv_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_if.key_value),
    .seed  (seed_r),
    .done  (hash_done),
    .hash  (hash_val)
  );

  kmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (EST_NUM),
    .den   (rd_q),
    .done  (div_done),
    .quo   (quo)
  );

  // shift direction depends on whether an entry is evicted
  assign src_idx = full ? mv_r : mv_r - 1'b1;
  assign dst_idx = full ? mv_r - 1'b1 : mv_r;
  assign put_idx = full ? above_r - 1'b1 : above_r;

  // drive store addresses
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dst_idx[ADDR_W-1:0];
    mem_wdata = rd_q;
    case (state_r)
      S_SCAN_RD: mem_raddr = idx_r[ADDR_W-1:0];
      S_MV_RD:   mem_raddr = src_idx[ADDR_W-1:0];
      default:   mem_raddr = '0;
    endcase
    if (state_r == S_MV_WR) begin
      mem_we = 1'b1;
    end else if (state_r == S_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = put_idx[ADDR_W-1:0];
      mem_wdata = h_r;
    end
  end

  // hash store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_if.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r <= in_if.req_type;
            est_r <= '0;
            sat_r <= 1'b0;
            if (in_if.req_type == REQ_INSERT) begin
              state_r <= S_HASH;
            end else begin
              if (in_if.req_type == REQ_CLEAR) cnt_r <= '0;
              state_r <= S_TOP_RD;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            h_r     <= hash_val;
            idx_r   <= '0;
            state_r <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (idx_r == cnt_r) begin
            above_r <= idx_r;
            state_r <= S_PLAN;
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (rd_q == h_r) begin
            state_r <= S_TOP_RD;
          end else if (rd_q < h_r) begin
            above_r <= idx_r;
            state_r <= S_PLAN;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_PLAN: begin
          if (full && above_r == '0) begin
            state_r <= S_TOP_RD;
          end else begin
            mv_r    <= full ? CNT_W'(1) : cnt_r;
            state_r <= S_MV_RD;
          end
        end
        S_MV_RD: begin
          if (full ? (mv_r >= above_r) : (mv_r <= above_r)) state_r <= S_PUT;
          else                                                state_r <= S_MV_WR;
        end
        S_MV_WR: begin
          mv_r    <= full ? mv_r + 1'b1 : mv_r - 1'b1;
          state_r <= S_MV_RD;
        end
        S_PUT: begin
          if (!full) cnt_r <= cnt_r + 1'b1;
          state_r <= S_TOP_RD;
        end
        S_TOP_RD: state_r <= S_TOP_CHK;
        S_TOP_CHK: begin
          largest_r <= (cnt_r != '0) ? rd_q : '0;
          state_r   <= S_OUT;
          if (req_r == REQ_QUERY) begin
            if (!full) begin
              est_r <= EST_W'(cnt_r);
            end else if (rd_q == '0) begin
              est_r <= EST_MAX;
              sat_r <= 1'b1;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            est_r   <= quo;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r   <= 1'b1;
            out_est_r     <= est_r;
            out_cnt_r     <= cnt_r;
            out_largest_r <= largest_r;
            out_sat_r     <= sat_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.estimate     = out_est_r;
  assign out_if.stored_count = out_cnt_r;
  assign out_if.largest_hash = out_largest_r;
  assign out_if.saturated    = out_sat_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SKETCH_SIZE)) else $error("fill count above sketch size");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PUT && !(in_acc && in_if.req_type == REQ_CLEAR)) |=> $stable(cnt_r))
    else $error("fill count changed outside insert or clear");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divide finished outside query");

  a_hash_state: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> state_r == S_HASH) else $error("hash finished outside insert");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_kmv_distinct_count_sketch_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmv_distinct_count_sketch_core
// Self-checking bench for the distinct-count sketch. Requests go in through a
// queue-fed driver with random gaps. Each accepted request runs through a
// local sketch model, which computes the MurmurHash2 key hash, the sorted
// store, the count and the estimate. A monitor compares every result, field by
// field, with the oldest predicted one. The bench fills the store past full
// and changes the hash seed between phases.
// ----------------------------------------------------------------------------
module tb_kmv_distinct_count_sketch_core;
  import kmv_pkg::*;

  localparam int LIMIT = 20_000_000;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
  } sketch_req_t;

  typedef struct {
    logic [EST_W-1:0]  estimate;
    logic [CNT_W-1:0]  count;
    logic [HASH_W-1:0] largest;
    logic              sat;
  } sketch_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kmv_in_if  in_if ();
  kmv_out_if out_if ();

  kmv_distinct_count_sketch_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // local sketch state
  logic [31:0]       seed_reg;
  logic [HASH_W-1:0] kept_hash [SKETCH_SIZE];
  int unsigned       kept_cnt;

  sketch_req_t pending_reqs[$];
  sketch_res_t pending_results[$];
  logic [KEY_W-1:0] used_keys[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;
  bit in_taken = 0;
  int in_gap = 0;
  int out_stall = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] murmur_hash(input logic [63:0] key,
                                              input logic [31:0] seed);
    logic [7:0]  b [8];
    logic [31:0] h, k;
    int len, pos;
    len = (KEY_BYTES > 8) ? 8 : KEY_BYTES;
    pos = 0;
    for (int i = 0; i < 8; i++) b[i] = key[8*i +: 8];
    h = seed ^ 32'(len);
    while (len - pos >= 4) begin
      k = {b[pos+3], b[pos+2], b[pos+1], b[pos]};
      k = k * MM_MUL;
      k ^= k >> 24;
      k = k * MM_MUL;
      h = h * MM_MUL;
      h ^= k;
      pos += 4;
    end
    if (len - pos == 3) h ^= {8'd0, b[pos+2], 16'd0};
    if (len - pos >= 2) h ^= {16'd0, b[pos+1], 8'd0};
    if (len - pos >= 1) begin
      h ^= {24'd0, b[pos]};
      h = h * MM_MUL;
    end
    h ^= h >> 13;
    h = h * MM_MUL;
    h ^= h >> 15;
    return h;
  endfunction

  task automatic sketch_add(input logic [31:0] h);
    int unsigned n, above;
    n = kept_cnt;
    above = 0;
    for (int i = 0; i < n; i++) begin
      if (kept_hash[i] == h) return;
      if (kept_hash[i] > h) above++;
    end
    if (n >= SKETCH_SIZE) begin
      // evict the largest, slide the larger ones up one slot
      if (kept_hash[0] <= h) return;
      for (int i = 0; i + 1 < above; i++) kept_hash[i] = kept_hash[i+1];
      kept_hash[above-1] = h;
      return;
    end
    for (int i = n; i > above; i--) kept_hash[i] = kept_hash[i-1];
    kept_hash[above] = h;
    kept_cnt = n + 1;
  endtask

  task automatic sketch_model_step(input sketch_req_t r);
    sketch_res_t res;
    logic [63:0] est;
    est = 0;
    res.sat = 1'b0;
    case (r.req)
      REQ_INSERT: sketch_add(murmur_hash(r.key, seed_reg));
      REQ_QUERY: begin
        if (kept_cnt < SKETCH_SIZE) begin
          est = kept_cnt;
        end else if (kept_hash[0] == 0) begin
          est = 64'(EST_MAX);
          res.sat = 1'b1;
        end else begin
          est = (K_MUL * 64'hFFFF_FFFF) / {32'd0, kept_hash[0]};
        end
      end
      REQ_CLEAR: kept_cnt = 0;
      default: ;
    endcase
    res.estimate = est[EST_W-1:0];
    res.count = CNT_W'(kept_cnt);
    res.largest = (kept_cnt > 0) ? kept_hash[0] : '0;
    pending_results.push_back(res);
  endtask

  // APB write from the falling edge; idle bus only
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2:2] == REG_HASH_SEED) seed_reg = data;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic push_req(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key);
    sketch_req_t r;
    r.req = req;
    r.key = key;
    pending_reqs.push_back(r);
    if (req == REQ_INSERT) used_keys.push_back(key);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_if.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // random mix; inserts dominate
  task automatic push_random(input int count, input bit allow_clear);
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < 82) push_req(REQ_INSERT, rand_key());
      else if (p < 89 && used_keys.size() > 0)
        push_req(REQ_INSERT, used_keys[$urandom_range(0, used_keys.size() - 1)]);
      else if (p < 96) push_req(REQ_QUERY, rand_key());
      else if (p < 98 || !allow_clear) push_req(2'd3, rand_key());
      else push_req(REQ_CLEAR, rand_key());
    end
  endtask

  // capture accepted requests and predict
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sketch_req_t r;
      r.req = in_if.req_type;
      r.key = in_if.key_value;
      sketch_model_step(r);
      in_taken = 1;
    end
  end

  // drive requests at the falling edge, with random gap bursts
  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = '0;
    in_if.key_value = '0;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      in_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid = 1'b0;
      end else if (pending_reqs.size() != 0) begin
        sketch_req_t r;
        r = pending_reqs.pop_front();
        in_if.req_type = r.req;
        in_if.key_value = r.key;
        in_if.valid = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 16);
      end else begin
        in_if.valid = 1'b0;
      end
    end
  end

  // result ready with random stall bursts
  initial out_if.ready = 1'b0;

  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_if.ready = rst_n;
    end else if (out_stall > 0) begin
      out_stall--;
      out_if.ready = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 15);
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // check each result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_if.stored_count), 0);
      end else begin
        sketch_res_t w;
        w = pending_results.pop_front();
        if (out_if.estimate !== w.estimate)
          report_mismatch("estimate", 64'(out_if.estimate), 64'(w.estimate));
        if (out_if.stored_count !== w.count)
          report_mismatch("stored_count", 64'(out_if.stored_count), 64'(w.count));
        if (out_if.largest_hash !== w.largest)
          report_mismatch("largest_hash", 64'(out_if.largest_hash), 64'(w.largest));
        if (out_if.saturated !== w.sat)
          report_mismatch("saturated", 64'(out_if.saturated), 64'(w.sat));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    seed_reg = '0;
    kept_cnt = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, duplicate, unused request, clear
    push_req(REQ_QUERY, '0);
    push_req(REQ_INSERT, '1);
    push_req(REQ_INSERT, '0);
    push_req(REQ_INSERT, '1);
    push_req(REQ_INSERT, 64'h5555_5555_5555_5555);
    push_req(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    push_req(REQ_QUERY, '1);
    push_req(2'd3, '1);
    push_req(REQ_CLEAR, '0);
    push_req(REQ_QUERY, '0);
    push_req(REQ_INSERT, 64'h0123_4567_89AB_CDEF);
    push_req(REQ_INSERT, 64'h0123_4567_89AB_CDEF);
    push_req(REQ_QUERY, '0);
    wait_drained();

    // unused register is ignored; then a random seed and a fill past full
    cfg_write(3'd4, $urandom());
    cfg_write(3'd0, $urandom());
    push_req(REQ_CLEAR, '0);
    for (int i = 0; i < 1030; i++) begin
      push_req(REQ_INSERT, rand_key());
      if (i % 64 == 63) push_req(REQ_QUERY, rand_key());
    end
    push_random(20, 0);
    // full store: queries and inserts, large and small hashes
    for (int i = 0; i < 15; i++) begin
      push_req(REQ_INSERT, rand_key());
      push_req(REQ_QUERY, rand_key());
    end
    wait_drained();

    // all-ones seed, mixed traffic with clears
    cfg_write(3'd0, 32'hFFFF_FFFF);
    push_random(30, 1);
    wait_drained();

    // zero seed again, last part without idling
    cfg_write(3'd0, 32'h0);
    quiet = 1;
    push_random(30, 1);
    push_req(REQ_QUERY, '0);
    wait_drained();

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
